>>> sv/grf_pkg.sv
// ----------------------------------------------------------------------------
// grf_pkg: shared types and constants of the gate run fuser
// widths, command and gate kind codes, result kind codes
// ----------------------------------------------------------------------------
package grf_pkg;

   localparam int AXIS_W        = 6;
   localparam int WORD_W        = 64;
   localparam int MASK_W        = 64;
   localparam int AXIS_COUNT_DF = 64;

   // command codes
   localparam logic CMD_ITEM  = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // input gate kinds, code three behaves as an other instruction
   typedef enum logic [1:0] {
      GK_OTHER = 2'd0,
      GK_CNOT  = 2'd1,
      GK_CZ    = 2'd2,
      GK_RSVD  = 2'd3
   } gate_kind_type;

   // result kinds
   typedef enum logic [2:0] {
      OK_PASS       = 3'd0,
      OK_CNOT       = 3'd1,
      OK_MULTI_CNOT = 3'd2,
      OK_CZ         = 3'd3,
      OK_MULTI_CZ   = 3'd4
   } out_kind_type;

endpackage

>>> sv/grf_req_if.sv
// ----------------------------------------------------------------------------
// grf_req_if: instruction channel
// valid/ready handshake carrying one instruction word
// ----------------------------------------------------------------------------
interface grf_req_if;

   logic                               valid;
   logic                               ready;
   logic                               cmd;
   grf_pkg::gate_kind_type             gate_kind;
   logic [grf_pkg::AXIS_W-1:0]         control_axis;
   logic [grf_pkg::AXIS_W-1:0]         target_axis;
   logic [grf_pkg::WORD_W-1:0]         payload;

   modport source (
      output valid, cmd, gate_kind, control_axis, target_axis, payload,
      input  ready
   );

   modport sink (
      input  valid, cmd, gate_kind, control_axis, target_axis, payload,
      output ready
   );

endinterface

>>> sv/grf_rsp_if.sv
// ----------------------------------------------------------------------------
// grf_rsp_if: result channel
// valid/ready handshake carrying one fused or forwarded gate word
// ----------------------------------------------------------------------------
interface grf_rsp_if;

   logic                               valid;
   logic                               ready;
   grf_pkg::out_kind_type              out_kind;
   logic [grf_pkg::AXIS_W-1:0]         out_control;
   logic [grf_pkg::AXIS_W-1:0]         out_target;
   logic [grf_pkg::MASK_W-1:0]         out_mask;
   logic [grf_pkg::WORD_W-1:0]         out_payload;
   logic                               last;

   modport source (
      output valid, out_kind, out_control, out_target, out_mask, out_payload, last,
      input  ready
   );

   modport sink (
      input  valid, out_kind, out_control, out_target, out_mask, out_payload, last,
      output ready
   );

endinterface

>>> sv/gate_run_fuser_top.sv
// ----------------------------------------------------------------------------
// gate_run_fuser_top: peephole fuser for CNOT and CZ runs
// merges runs of gates on a shared axis into single or multi gates
// ----------------------------------------------------------------------------
// usage
//   req_ch takes one instruction word per handshake: an instruction or an
//   end-of-stream flush command. rsp_ch returns the fused gates and the
//   forwarded instructions, in stream order, with last set on the final
//   word caused by one request word.
//   a CNOT or CZ that extends the open run updates the run state and
//   returns nothing. a word that ends a run returns the fused gate (none
//   when the run cancelled out), then the forwarded instruction if any.
// pipeline and throughput
//   a request word's results pass through the pending-word register, then
//   the result register. one request word per cycle while rsp_ch.ready
//   is high and each word causes at most one result; a word causing a
//   flush plus a passthrough holds req_ch.ready low until the single result
//   register has drained the fused gate from the pending-word register
// reset
//   synchronous, active high: run closed, mask cleared, both registers empty
// stall
//   while rsp_ch.ready is low the result register holds; the pending-word
//   register takes words until one queues a result, then req_ch.ready drops
// ----------------------------------------------------------------------------
module gate_run_fuser_top #(
   parameter int AXIS_COUNT = grf_pkg::AXIS_COUNT_DF
) (
   input logic        clock,
   input logic        reset,
   grf_req_if.sink    req_ch,
   grf_rsp_if.source  rsp_ch
);

   localparam int AW = grf_pkg::AXIS_W;

   // run state
   logic                  run_open_ff,  run_open_in;
   logic                  run_is_cz_ff, run_is_cz_in;
   logic [AW-1:0]         run_axis_ff,  run_axis_in;
   logic [AXIS_COUNT-1:0] run_mask_ff,  run_mask_in;

   // pending word: the closed run to emit and the word to forward
   logic                  ev_flush_ff,  ev_flush_in;
   logic                  ev_pass_ff,   ev_pass_in;
   logic                  ev_cz_ff,     ev_cz_in;
   logic [AW-1:0]         ev_axis_ff,   ev_axis_in;
   logic [AXIS_COUNT-1:0] ev_mask_ff,   ev_mask_in;
   logic [grf_pkg::WORD_W-1:0] ev_pay_ff, ev_pay_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   grf_pkg::out_kind_type      rsp_kind_ff,  rsp_kind_in;
   logic [AW-1:0]              rsp_ctl_ff,   rsp_ctl_in;
   logic [AW-1:0]              rsp_tgt_ff,   rsp_tgt_in;
   logic [grf_pkg::MASK_W-1:0] rsp_mask_ff,  rsp_mask_in;
   logic [grf_pkg::WORD_W-1:0] rsp_pay_ff,   rsp_pay_in;
   logic                       rsp_last_ff,  rsp_last_in;

   // input decode
   logic                  accept;
   logic                  out_free;
   logic                  is_gate;
   logic                  is_cz;
   logic [AW-1:0]         shared_axis;
   logic [AW-1:0]         other_axis;
   logic                  joins;
   logic [AXIS_COUNT-1:0] axis_bit;

   // flush encode
   logic                  ev_multi;
   logic [AW-1:0]         ev_low;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // room while the pending word empties this cycle or is empty
   assign req_ch.ready = !(ev_flush_ff || ev_pass_ff) ||
                         (out_free && !(ev_flush_ff && ev_pass_ff));
   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      is_gate = (req_ch.cmd == grf_pkg::CMD_ITEM) &&
                ((req_ch.gate_kind == grf_pkg::GK_CNOT) ||
                 (req_ch.gate_kind == grf_pkg::GK_CZ));
      is_cz       = (req_ch.gate_kind == grf_pkg::GK_CZ);
      shared_axis = is_cz ? req_ch.control_axis : req_ch.target_axis;
      other_axis  = is_cz ? req_ch.target_axis  : req_ch.control_axis;
      joins       = run_open_ff && (run_is_cz_ff == is_cz) && (run_axis_ff == shared_axis);
      // axes beyond the mask width toggle nothing
      for (int i = 0; i < AXIS_COUNT; i++) begin
         axis_bit[i] = (other_axis == AW'(i));
      end
   end

   // lowest set bit of a one-hot mask: an or of the set bit indexes
   always_comb begin
      ev_multi = (ev_mask_ff & (ev_mask_ff - AXIS_COUNT'(1))) != '0;
      ev_low   = '0;
      for (int i = 0; i < AXIS_COUNT; i++) begin
         ev_low = ev_low | (ev_mask_ff[i] ? AW'(i) : AW'(0));
      end
   end

   always_comb begin
      run_open_in  = run_open_ff;
      run_is_cz_in = run_is_cz_ff;
      run_axis_in  = run_axis_ff;
      run_mask_in  = run_mask_ff;

      ev_flush_in = ev_flush_ff;
      ev_pass_in  = ev_pass_ff;
      ev_cz_in    = ev_cz_ff;
      ev_axis_in  = ev_axis_ff;
      ev_mask_in  = ev_mask_ff;
      ev_pay_in   = ev_pay_ff;

      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_ctl_in   = rsp_ctl_ff;
      rsp_tgt_in   = rsp_tgt_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_pay_in   = rsp_pay_ff;
      rsp_last_in  = rsp_last_ff;

      // drain the pending word into the result register, run first
      if (out_free) begin
         rsp_valid_in = 1'b0;
         priority if (ev_flush_ff) begin
            rsp_valid_in = 1'b1;
            rsp_mask_in  = '0;
            rsp_pay_in   = '0;
            rsp_last_in  = !ev_pass_ff;
            if (ev_cz_ff) begin
               rsp_ctl_in = ev_axis_ff;
               if (ev_multi) begin
                  rsp_kind_in = grf_pkg::OK_MULTI_CZ;
                  rsp_tgt_in  = '0;
                  rsp_mask_in = grf_pkg::MASK_W'(ev_mask_ff);
               end else begin
                  rsp_kind_in = grf_pkg::OK_CZ;
                  rsp_tgt_in  = ev_low;
               end
            end else begin
               rsp_tgt_in = ev_axis_ff;
               if (ev_multi) begin
                  rsp_kind_in = grf_pkg::OK_MULTI_CNOT;
                  rsp_ctl_in  = '0;
                  rsp_mask_in = grf_pkg::MASK_W'(ev_mask_ff);
               end else begin
                  rsp_kind_in = grf_pkg::OK_CNOT;
                  rsp_ctl_in  = ev_low;
               end
            end
            ev_flush_in = 1'b0;
         end else if (ev_pass_ff) begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = grf_pkg::OK_PASS;
            rsp_ctl_in   = '0;
            rsp_tgt_in   = '0;
            rsp_mask_in  = '0;
            rsp_pay_in   = ev_pay_ff;
            rsp_last_in  = 1'b1;
            ev_pass_in   = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end

      // new word: close or extend the run, queue what it emits
      if (accept) begin
         // flush and other words always close the run, gates only on a break
         ev_flush_in = (!is_gate || !joins) && run_open_ff && (run_mask_ff != '0);
         ev_pass_in  = (req_ch.cmd == grf_pkg::CMD_ITEM) && !is_gate;
         ev_cz_in    = run_is_cz_ff;
         ev_axis_in  = run_axis_ff;
         ev_mask_in  = run_mask_ff;
         ev_pay_in   = req_ch.payload;
         if (is_gate) begin
            if (joins) begin
               run_mask_in = run_mask_ff ^ axis_bit;
            end else begin
               run_open_in  = 1'b1;
               run_is_cz_in = is_cz;
               run_axis_in  = shared_axis;
               run_mask_in  = axis_bit;
            end
         end else begin
            run_open_in = 1'b0;
            run_mask_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff  <= 1'b0;
         run_is_cz_ff <= 1'b0;
         run_axis_ff  <= '0;
         run_mask_ff  <= '0;
         ev_flush_ff  <= 1'b0;
         ev_pass_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_open_ff  <= run_open_in;
         run_is_cz_ff <= run_is_cz_in;
         run_axis_ff  <= run_axis_in;
         run_mask_ff  <= run_mask_in;
         ev_flush_ff  <= ev_flush_in;
         ev_pass_ff   <= ev_pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ev_cz_ff    <= ev_cz_in;
      ev_axis_ff  <= ev_axis_in;
      ev_mask_ff  <= ev_mask_in;
      ev_pay_ff   <= ev_pay_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_ctl_ff  <= rsp_ctl_in;
      rsp_tgt_ff  <= rsp_tgt_in;
      rsp_mask_ff <= rsp_mask_in;
      rsp_pay_ff  <= rsp_pay_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_kind    = rsp_kind_ff;
   assign rsp_ch.out_control = rsp_ctl_ff;
   assign rsp_ch.out_target  = rsp_tgt_ff;
   assign rsp_ch.out_mask    = rsp_mask_ff;
   assign rsp_ch.out_payload = rsp_pay_ff;
   assign rsp_ch.last        = rsp_last_ff;

   // a full pending word must block the request side
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (ev_flush_ff && ev_pass_ff) |-> !req_ch.ready)
      else $error("request taken while two results pending");

   // end of stream always closes the run
   a_flush_closes: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.cmd == grf_pkg::CMD_FLUSH) |=> !run_open_ff)
      else $error("run still open after end of stream");

   // a closed run carries no mask
   a_closed_empty: assert property (@(posedge clock) disable iff (reset)
      !run_open_ff |-> (run_mask_ff == '0))
      else $error("closed run holds mask bits");

   // a result without last is a fused gate with a forwarded word behind it
   a_last_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (ev_pass_ff && rsp_kind_ff != grf_pkg::OK_PASS))
      else $error("non-final result without a pending forwarded word");

endmodule
